>>> rtl/dmxtx_pkg.sv
// ----------------------------------------------------------------------------
// dmxtx_pkg
// shared types and constants of the dmx512 frame transmitter
// ----------------------------------------------------------------------------
package dmxtx_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_BREAK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAB   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP  = 2'd2;

  localparam logic [5:0] BREAK_RST = 6'd22;
  localparam logic [2:0] MAB_RST   = 3'd2;
  localparam logic [2:0] STOP_RST  = 3'd4;

  localparam logic [5:0] BREAK_MIN = 6'd22;
  localparam logic [5:0] BREAK_MAX = 6'd32;
  localparam logic [2:0] MAB_MIN   = 3'd2;
  localparam logic [2:0] MAB_MAX   = 3'd4;
  localparam logic [2:0] STOP_MIN  = 3'd2;
  localparam logic [2:0] STOP_MAX  = 3'd4;

  localparam logic [7:0] START_CODE = 8'h00;

  localparam logic [2:0] KIND_BREAK = 3'd0;
  localparam logic [2:0] KIND_MAB   = 3'd1;
  localparam logic [2:0] KIND_START = 3'd2;
  localparam logic [2:0] KIND_DATA  = 3'd3;
  localparam logic [2:0] KIND_STOP  = 3'd4;

  localparam logic [4:0] DATA_LAST = 5'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       frame;
    logic [4:0] brk_last;
    logic [1:0] mab_last;
    logic [1:0] stop_last;
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BREAK,
    PH_MAB,
    PH_START,
    PH_DATA,
    PH_STOP
  } phase_t;

endpackage

>>> rtl/dmxtx_front.sv
// ----------------------------------------------------------------------------
// dmxtx_front
// config registers, request intake and command build for the bit sequencer
// ----------------------------------------------------------------------------
module dmxtx_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dmxtx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmxtx_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_slot_data,
  input  logic                            in_frame_start,
  output logic                            push_valid,
  output dmxtx_pkg::cmd_t                 push_cmd,
  input  logic                            push_ready
);

  logic [5:0] break_r, break_nxt;
  logic [2:0] mab_r, mab_nxt;
  logic [2:0] stop_r, stop_nxt;
  logic [5:0] brk_c;
  logic [2:0] mab_c;
  logic [2:0] stop_c;
  logic [5:0] brk_m1;
  logic [2:0] mab_m1;
  logic [2:0] stop_m1;

  assign cfg_ready = 1'b1;

  always_comb begin
    break_nxt = break_r;
    mab_nxt   = mab_r;
    stop_nxt  = stop_r;
    if (cfg_valid) begin
      case (cfg_index)
        dmxtx_pkg::CFG_BREAK: break_nxt = cfg_data;
        dmxtx_pkg::CFG_MAB:   mab_nxt   = cfg_data[2:0];
        dmxtx_pkg::CFG_STOP:  stop_nxt  = cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      break_r <= dmxtx_pkg::BREAK_RST;
      mab_r   <= dmxtx_pkg::MAB_RST;
      stop_r  <= dmxtx_pkg::STOP_RST;
    end else begin
      break_r <= break_nxt;
      mab_r   <= mab_nxt;
      stop_r  <= stop_nxt;
    end
  end

  // clamp into legal range
  always_comb begin
    brk_c = break_r;
    if (break_r < dmxtx_pkg::BREAK_MIN) brk_c = dmxtx_pkg::BREAK_MIN;
    else if (break_r > dmxtx_pkg::BREAK_MAX) brk_c = dmxtx_pkg::BREAK_MAX;
    mab_c = mab_r;
    if (mab_r < dmxtx_pkg::MAB_MIN) mab_c = dmxtx_pkg::MAB_MIN;
    else if (mab_r > dmxtx_pkg::MAB_MAX) mab_c = dmxtx_pkg::MAB_MAX;
    stop_c = stop_r;
    if (stop_r < dmxtx_pkg::STOP_MIN) stop_c = dmxtx_pkg::STOP_MIN;
    else if (stop_r > dmxtx_pkg::STOP_MAX) stop_c = dmxtx_pkg::STOP_MAX;
  end

  assign brk_m1  = brk_c - 6'd1;
  assign mab_m1  = mab_c - 3'd1;
  assign stop_m1 = stop_c - 3'd1;

  assign push_cmd.data      = in_slot_data;
  assign push_cmd.frame     = in_frame_start;
  assign push_cmd.brk_last  = brk_m1[4:0];
  assign push_cmd.mab_last  = mab_m1[1:0];
  assign push_cmd.stop_last = stop_m1[1:0];

  assign push_valid = in_valid;
  assign in_stall   = !push_ready;

endmodule

>>> rtl/dmxtx_fifo.sv
// ----------------------------------------------------------------------------
// dmxtx_fifo
// short command queue between intake and bit sequencer
// ----------------------------------------------------------------------------
module dmxtx_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  input  dmxtx_pkg::cmd_t wr_cmd,
  output logic            wr_ready,
  output logic            rd_valid,
  output dmxtx_pkg::cmd_t rd_cmd,
  input  logic            rd_pop,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dmxtx_pkg::cmd_t        mem_r [DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   do_wr;
  logic                   do_rd;

  assign wr_ready = count_r != CNT_FULL;
  assign rd_valid = count_r != '0;
  assign rd_cmd   = mem_r[rd_ptr_r];
  assign count    = count_r;

  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (do_wr && !do_rd) count_nxt = count_r + 1'b1;
    else if (do_rd && !do_wr) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_cmd;
  end

endmodule

>>> rtl/dmxtx_back.sv
// ----------------------------------------------------------------------------
// dmxtx_back
// bit sequencer: break, mab, framed bytes, one bit time per output
// ----------------------------------------------------------------------------
module dmxtx_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  input  dmxtx_pkg::cmd_t cmd,
  output logic            cmd_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_line_level,
  output logic [2:0]      out_symbol_kind,
  output logic            out_run_last
);

  dmxtx_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              code_r, code_nxt;
  dmxtx_pkg::cmd_t   cmd_r, cmd_nxt;
  logic              out_valid_r;
  logic              level_r;
  logic [2:0]        kind_r;
  logic              last_r;
  logic              adv;
  logic              emit;
  logic              bit_level;
  logic [2:0]        bit_kind;
  logic              bit_last;
  logic              seg_end;
  logic [7:0]        cur_byte;

  assign adv      = !out_valid_r || !out_stall;
  assign emit     = adv && (phase_r != dmxtx_pkg::PH_IDLE);
  assign cur_byte = code_r ? dmxtx_pkg::START_CODE : cmd_r.data;
  assign cmd_pop  = cmd_valid && ((phase_r == dmxtx_pkg::PH_IDLE) || (adv && bit_last));

  // output decode
  always_comb begin
    bit_level = 1'b1;
    bit_kind  = dmxtx_pkg::KIND_STOP;
    bit_last  = 1'b0;
    seg_end   = 1'b0;
    case (phase_r)
      dmxtx_pkg::PH_BREAK: begin
        bit_level = 1'b0;
        bit_kind  = dmxtx_pkg::KIND_BREAK;
        seg_end   = cnt_r == cmd_r.brk_last;
      end
      dmxtx_pkg::PH_MAB: begin
        bit_level = 1'b1;
        bit_kind  = dmxtx_pkg::KIND_MAB;
        seg_end   = cnt_r == {3'b000, cmd_r.mab_last};
      end
      dmxtx_pkg::PH_START: begin
        bit_level = 1'b0;
        bit_kind  = dmxtx_pkg::KIND_START;
        seg_end   = 1'b1;
      end
      dmxtx_pkg::PH_DATA: begin
        bit_level = cur_byte[cnt_r[2:0]];
        bit_kind  = dmxtx_pkg::KIND_DATA;
        seg_end   = cnt_r == dmxtx_pkg::DATA_LAST;
      end
      dmxtx_pkg::PH_STOP: begin
        bit_level = 1'b1;
        bit_kind  = dmxtx_pkg::KIND_STOP;
        seg_end   = cnt_r == {3'b000, cmd_r.stop_last};
        bit_last  = seg_end && !code_r;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    code_nxt  = code_r;
    cmd_nxt   = cmd_r;
    if (cmd_pop) begin
      cmd_nxt   = cmd;
      code_nxt  = cmd.frame;
      cnt_nxt   = '0;
      phase_nxt = cmd.frame ? dmxtx_pkg::PH_BREAK : dmxtx_pkg::PH_START;
    end else if (emit) begin
      cnt_nxt = cnt_r + 5'd1;
      if (seg_end) begin
        cnt_nxt = '0;
        case (phase_r)
          dmxtx_pkg::PH_BREAK: phase_nxt = dmxtx_pkg::PH_MAB;
          dmxtx_pkg::PH_MAB:   phase_nxt = dmxtx_pkg::PH_START;
          dmxtx_pkg::PH_START: phase_nxt = dmxtx_pkg::PH_DATA;
          dmxtx_pkg::PH_DATA:  phase_nxt = dmxtx_pkg::PH_STOP;
          dmxtx_pkg::PH_STOP: begin
            if (code_r) begin
              code_nxt  = 1'b0;
              phase_nxt = dmxtx_pkg::PH_START;
            end else begin
              phase_nxt = dmxtx_pkg::PH_IDLE;
            end
          end
          default: phase_nxt = dmxtx_pkg::PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dmxtx_pkg::PH_IDLE;
      cnt_r       <= '0;
      code_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      code_r  <= code_nxt;
      if (adv) out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (emit) begin
      level_r <= bit_level;
      kind_r  <= bit_kind;
      last_r  <= bit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_line_level  = level_r;
  assign out_symbol_kind = kind_r;
  assign out_run_last    = last_r;

endmodule

>>> rtl/dmx512_frame_transmitter_unit.sv
// ----------------------------------------------------------------------------
// dmx512_frame_transmitter_unit
// dmx512 slot serializer, one output per bit time
// ----------------------------------------------------------------------------
// each input request carries a slot byte and a frame-start flag. the output
// channel gives one line level per bit time with its symbol kind; pacing to
// 4 us per bit is done by a divider downstream. a frame start sends break,
// mark after break and start code 0x00 before the slot byte. every byte is a
// low start bit, eight data bits lsb first and 2..4 high stop bits.
// a slot is 9 + stop_bit_count output bits, 11..13 (13 at the default
// of four stop bits); a frame start adds break + mab + 9 + stops.
// the bit sequencer emits one bit per cycle unless the receiver stalls, and
// it moves straight from the last stop bit of one request to the first bit
// of the next queued one. from idle, an accepted request passes the queue
// and the phase register before its first bit is registered. config writes
// are taken every cycle (cfg_ready high) and land in the next request built
// by the intake; write only while idle. reset restores 22 / 2 / 4 and
// empties the queue. when the receiver stalls, the current bit is held, the
// sequencer freezes, the command queue fills and in_stall rises once full.
// ----------------------------------------------------------------------------
module dmx512_frame_transmitter_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dmxtx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmxtx_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_slot_data,
  input  logic                             in_frame_start,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_line_level,
  output logic [2:0]                       out_symbol_kind,
  output logic                             out_run_last
);

  logic                               push_valid;
  logic                               push_ready;
  dmxtx_pkg::cmd_t                    push_cmd;
  logic                               q_valid;
  dmxtx_pkg::cmd_t                    q_cmd;
  logic                               q_pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count;

  dmxtx_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_slot_data   (in_slot_data),
    .in_frame_start (in_frame_start),
    .push_valid     (push_valid),
    .push_cmd       (push_cmd),
    .push_ready     (push_ready)
  );

  dmxtx_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_cmd   (push_cmd),
    .wr_ready (push_ready),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd),
    .rd_pop   (q_pop),
    .count    (q_count)
  );

  dmxtx_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (q_valid),
    .cmd             (q_cmd),
    .cmd_pop         (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_line_level  (out_line_level),
    .out_symbol_kind (out_symbol_kind),
    .out_run_last    (out_run_last)
  );

  a_last_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_last |-> out_symbol_kind == dmxtx_pkg::KIND_STOP && out_line_level)
    else $error("run_last on a non stop bit");

  a_mab_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_symbol_kind == dmxtx_pkg::KIND_MAB |=>
      !out_valid || out_symbol_kind == dmxtx_pkg::KIND_MAB ||
      out_symbol_kind == dmxtx_pkg::KIND_START)
    else $error("mark after break not followed by mab or start bit");

  a_start_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_symbol_kind == dmxtx_pkg::KIND_START |=>
      !out_valid || out_symbol_kind == dmxtx_pkg::KIND_DATA)
    else $error("start bit not followed by data bit");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_count == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("input stalled with room in the queue");

endmodule

>>> dv/dmx512_frame_transmitter_unit_tb.sv
// ----------------------------------------------------------------------------
// dmx512_frame_transmitter_unit_tb
// self-checking testbench of the dmx512 slot serializer
// ----------------------------------------------------------------------------
// a scoreboard class builds the bit-time sequence of every accepted slot
// request (break, mark after break and start code on a frame start, then the
// framed slot byte) from its own copy of the three registers and compares
// each accepted output bit time with the oldest expected one. a directed
// part walks the register extremes, out-of-range values, the unused index
// and the data byte extremes; random phases follow with random settings,
// idle bursts on both sides, one long receiver hold that backs up the input,
// and a final phase without idling.
// ----------------------------------------------------------------------------
module dmx512_frame_transmitter_unit_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 300;

  localparam logic [dmxtx_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic       level;
    logic [2:0] kind;
    logic       last;
  } line_bit_t;

  class dmx_line_scoreboard;
    line_bit_t  expected_bits[$];
    logic [5:0] brk_reg;
    logic [2:0] mab_reg;
    logic [2:0] stop_reg;
    int         errors;
    int         n_requests;
    int         n_frames;
    int         n_checked;
    int         n_writes;

    function new();
      brk_reg  = dmxtx_pkg::BREAK_RST;
      mab_reg  = dmxtx_pkg::MAB_RST;
      stop_reg = dmxtx_pkg::STOP_RST;
    endfunction

    function int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_reg(logic [dmxtx_pkg::CFG_IDX_W-1:0] idx,
                          logic [dmxtx_pkg::CFG_DATA_W-1:0] val);
      n_writes++;
      case (idx)
        dmxtx_pkg::CFG_BREAK: brk_reg  = val;
        dmxtx_pkg::CFG_MAB:   mab_reg  = val[2:0];
        dmxtx_pkg::CFG_STOP:  stop_reg = val[2:0];
        default: ;
      endcase
    endfunction

    function void push_bit(logic level, logic [2:0] kind);
      line_bit_t b;
      b.level = level;
      b.kind  = kind;
      b.last  = 1'b0;
      expected_bits.push_back(b);
    endfunction

    function void push_byte(logic [7:0] value, int stops);
      push_bit(1'b0, dmxtx_pkg::KIND_START);
      for (int i = 0; i < 8; i++) push_bit(value[i], dmxtx_pkg::KIND_DATA);
      repeat (stops) push_bit(1'b1, dmxtx_pkg::KIND_STOP);
    endfunction

    function void note_request(logic [7:0] slot, logic frame);
      int        stops;
      int        brk;
      int        mab;
      line_bit_t tail;
      stops = clamp(int'(stop_reg), int'(dmxtx_pkg::STOP_MIN), int'(dmxtx_pkg::STOP_MAX));
      brk   = clamp(int'(brk_reg), int'(dmxtx_pkg::BREAK_MIN), int'(dmxtx_pkg::BREAK_MAX));
      mab   = clamp(int'(mab_reg), int'(dmxtx_pkg::MAB_MIN), int'(dmxtx_pkg::MAB_MAX));
      n_requests++;
      if (frame) begin
        n_frames++;
        repeat (brk) push_bit(1'b0, dmxtx_pkg::KIND_BREAK);
        repeat (mab) push_bit(1'b1, dmxtx_pkg::KIND_MAB);
        push_byte(dmxtx_pkg::START_CODE, stops);
      end
      push_byte(slot, stops);
      tail = expected_bits.pop_back();
      tail.last = 1'b1;
      expected_bits.push_back(tail);
    endfunction

    function void mismatch(string what, int exp_val, int act_val);
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_val, act_val);
    endfunction

    function void check_result(line_bit_t got);
      line_bit_t want;
      n_checked++;
      if (expected_bits.size() == 0) begin
        errors++;
        $display("%0t: unexpected bit time, expected none actual level %0d kind %0d last %0d",
                 $time, got.level, got.kind, got.last);
        return;
      end
      want = expected_bits.pop_front();
      if (got.level !== want.level)
        mismatch("line_level", int'(want.level), int'(got.level));
      if (got.kind !== want.kind)
        mismatch("symbol_kind", int'(want.kind), int'(got.kind));
      if (got.last !== want.last)
        mismatch("run_last", int'(want.last), int'(got.last));
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [dmxtx_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dmxtx_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                             in_valid;
  logic                             in_stall;
  logic [7:0]                       in_slot_data;
  logic                             in_frame_start;
  logic                             out_valid;
  logic                             out_stall;
  logic                             out_line_level;
  logic [2:0]                       out_symbol_kind;
  logic                             out_run_last;

  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;
  int idle_cycles;

  dmx_line_scoreboard sb;

  dmx512_frame_transmitter_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_slot_data    (in_slot_data),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_line_level  (out_line_level),
    .out_symbol_kind (out_symbol_kind),
    .out_run_last    (out_run_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver: random stall bursts, one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (int k = 0; k < LONG_HOLD; k++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_on && rst_n && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    line_bit_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.level = out_line_level;
      got.kind  = out_symbol_kind;
      got.last  = out_run_last;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
        $display("dmx512_frame_transmitter_unit_tb failed");
        $finish;
      end
    end
  end

  task write_reg(input logic [dmxtx_pkg::CFG_IDX_W-1:0] idx,
                 input logic [dmxtx_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task apply_regs(input logic [5:0] brk, input logic [5:0] mab, input logic [5:0] stops);
    write_reg(dmxtx_pkg::CFG_BREAK, brk);
    write_reg(dmxtx_pkg::CFG_MAB, mab);
    write_reg(dmxtx_pkg::CFG_STOP, stops);
  endtask

  task send_slot(input logic [7:0] slot, input logic frame);
    in_valid       <= 1'b1;
    in_slot_data   <= slot;
    in_frame_start <= frame;
    do @(posedge clk); while (in_stall);
    sb.note_request(slot, frame);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task drain_outputs();
    in_valid <= 1'b0;
    while (sb.expected_bits.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task run_random_phase(input int count, input bit pressure);
    logic [5:0] brk;
    logic [5:0] mab;
    logic [5:0] stops;
    brk   = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(22, 32));
    mab   = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(2, 4));
    stops = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(2, 4));
    apply_regs(brk, mab, stops);
    if ($urandom_range(0, 1) == 1) write_reg(CFG_UNUSED, 6'($urandom));
    if (pressure) hold_req = 1'b1;
    for (int k = 0; k < count; k++) send_slot(8'($urandom), $urandom_range(0, 3) == 0);
    drain_outputs();
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = dmxtx_pkg::CFG_BREAK;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_slot_data   = '0;
    in_frame_start = 1'b0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    hold_req       = 1'b0;
    idle_cycles    = 0;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values
    send_slot(8'h00, 1'b1);
    send_slot(8'hFF, 1'b0);
    send_slot(8'h01, 1'b0);
    send_slot(8'h80, 1'b1);
    send_slot(8'hA5, 1'b0);
    send_slot(8'h5A, 1'b1);
    drain_outputs();

    // break and mab above range, upper bits ignored on 3-bit registers, unused index
    apply_regs(6'h3F, 6'h3F, 6'h38);
    write_reg(CFG_UNUSED, 6'h15);
    send_slot(8'hFF, 1'b1);
    send_slot(8'h00, 1'b0);
    send_slot(8'hC3, 1'b0);
    drain_outputs();

    // zero values, stop count above range
    apply_regs(6'd0, 6'd0, 6'd7);
    send_slot(8'h3C, 1'b1);
    send_slot(8'hFF, 1'b0);
    drain_outputs();

    // longest legal frame, shortest stop
    apply_regs(dmxtx_pkg::BREAK_MAX, 6'(dmxtx_pkg::MAB_MAX), 6'(dmxtx_pkg::STOP_MIN));
    send_slot(8'h00, 1'b1);
    send_slot(8'hFF, 1'b1);
    send_slot(8'h81, 1'b0);
    drain_outputs();

    // just outside each range
    apply_regs(6'd21, 6'd1, 6'd1);
    send_slot(8'h7E, 1'b1);
    drain_outputs();
    apply_regs(6'd33, 6'd5, 6'd5);
    send_slot(8'hAA, 1'b1);
    send_slot(8'h55, 1'b0);
    drain_outputs();

    // back to the shortest break and mab, with the longest stop
    apply_regs(dmxtx_pkg::BREAK_MIN, 6'(dmxtx_pkg::MAB_MIN), 6'(dmxtx_pkg::STOP_MAX));
    send_slot(8'hF0, 1'b1);
    send_slot(8'h0F, 1'b0);
    drain_outputs();

    run_random_phase(70, 1'b0);
    run_random_phase(70, 1'b0);
    run_random_phase(70, 1'b1);
    run_random_phase(70, 1'b0);
    run_random_phase(70, 1'b0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random_phase(70, 1'b0);
    repeat (10) @(posedge clk);

    $display("covered %0d slot requests, %0d with frame start, %0d bit times compared",
             sb.n_requests, sb.n_frames, sb.n_checked);
    $display("register writes: %0d, including out-of-range values and the unused index",
             sb.n_writes);
    if (sb.errors == 0 && sb.expected_bits.size() == 0) begin
      $display("dmx512_frame_transmitter_unit_tb passed");
    end else begin
      $display("dmx512_frame_transmitter_unit_tb failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/dmxtx_pkg.sv
rtl/dmxtx_front.sv
rtl/dmxtx_fifo.sv
rtl/dmxtx_back.sv
rtl/dmx512_frame_transmitter_unit.sv
dv/dmx512_frame_transmitter_unit_tb.sv
